[src/abd_pkg.sv]
// shared types and constants for the uart autobaud divisor block
`timescale 1ns / 1ps

package abd_pkg;

	// input command codes
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_EDGE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// select code that turns on the measurement
	localparam logic [2:0] SEL_AUTO = 3'b111;

	// measurement marks
	localparam logic [15:0] NO_INTERVAL = 16'hffff;
	localparam logic [7:0]  OVF_SAT     = 8'd255;
	localparam int unsigned DIV_MAX     = 4095;

	// fixed baud rates for selects 0..6
	localparam int unsigned BAUD_0 = 57600;
	localparam int unsigned BAUD_1 = 38400;
	localparam int unsigned BAUD_2 = 19200;
	localparam int unsigned BAUD_3 = 9600;
	localparam int unsigned BAUD_4 = 4800;
	localparam int unsigned BAUD_5 = 1200;
	localparam int unsigned BAUD_6 = 300;

	// one result word
	typedef struct packed {
		logic [11:0] divisor;
		logic        status;
	} result_t;

	// result word plus its strobe, core to output queue
	typedef struct packed {
		logic    valid;
		result_t data;
	} result_push_t;

endpackage

[src/abd_core.sv]
// measurement state and result logic, one word per cycle while accept is high
`timescale 1ns / 1ps

module abd_core import abd_pkg::*; #(
	parameter int unsigned CLOCK_HZ      = 16000000,
	parameter int unsigned EDGES_PER_TRY = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic [1:0]   cmd,
	input  logic [15:0]  edge_time,
	input  logic [2:0]   baud_select,
	output result_push_t push
);

	// fixed divisors, worked out at elaboration
	localparam int unsigned Q0 = CLOCK_HZ / (BAUD_0 * 16);
	localparam int unsigned Q1 = CLOCK_HZ / (BAUD_1 * 16);
	localparam int unsigned Q2 = CLOCK_HZ / (BAUD_2 * 16);
	localparam int unsigned Q3 = CLOCK_HZ / (BAUD_3 * 16);
	localparam int unsigned Q4 = CLOCK_HZ / (BAUD_4 * 16);
	localparam int unsigned Q5 = CLOCK_HZ / (BAUD_5 * 16);
	localparam int unsigned Q6 = CLOCK_HZ / (BAUD_6 * 16);
	localparam int unsigned D0 = (Q0 == 0) ? 0 : ((Q0 - 1 > DIV_MAX) ? DIV_MAX : Q0 - 1);
	localparam int unsigned D1 = (Q1 == 0) ? 0 : ((Q1 - 1 > DIV_MAX) ? DIV_MAX : Q1 - 1);
	localparam int unsigned D2 = (Q2 == 0) ? 0 : ((Q2 - 1 > DIV_MAX) ? DIV_MAX : Q2 - 1);
	localparam int unsigned D3 = (Q3 == 0) ? 0 : ((Q3 - 1 > DIV_MAX) ? DIV_MAX : Q3 - 1);
	localparam int unsigned D4 = (Q4 == 0) ? 0 : ((Q4 - 1 > DIV_MAX) ? DIV_MAX : Q4 - 1);
	localparam int unsigned D5 = (Q5 == 0) ? 0 : ((Q5 - 1 > DIV_MAX) ? DIV_MAX : Q5 - 1);
	localparam int unsigned D6 = (Q6 == 0) ? 0 : ((Q6 - 1 > DIV_MAX) ? DIV_MAX : Q6 - 1);
	localparam logic [3:0] EDGE_LIMIT = 4'(EDGES_PER_TRY);

	logic [15:0] min_interval_q;
	logic [15:0] last_edge_time_q;
	logic [7:0]  overflow_count_q;
	logic [3:0]  edge_count_q;
	logic        measuring_q;

	logic [11:0] fixed_div;
	logic        interval_ok;
	logic [15:0] interval;
	logic [15:0] min_next;
	logic [3:0]  edge_next;
	logic        try_done;
	cmd_t        cmd_e;

	assign cmd_e = cmd_t'(cmd);

	// fixed divisor lookup
	always_comb begin
		case (baud_select)
			3'd0:    fixed_div = 12'(D0);
			3'd1:    fixed_div = 12'(D1);
			3'd2:    fixed_div = 12'(D2);
			3'd3:    fixed_div = 12'(D3);
			3'd4:    fixed_div = 12'(D4);
			3'd5:    fixed_div = 12'(D5);
			3'd6:    fixed_div = 12'(D6);
			default: fixed_div = 12'd0;
		endcase
	end

	// interval check and new minimum
	assign interval    = edge_time - last_edge_time_q;
	assign interval_ok = (overflow_count_q < 8'd2) &&
		((edge_time <= last_edge_time_q) || (overflow_count_q == 8'd0));
	assign min_next    = (interval_ok && (interval < min_interval_q)) ? interval : min_interval_q;
	assign edge_next   = edge_count_q + 4'd1;
	assign try_done    = (edge_next >= EDGE_LIMIT);

	// result word for the accepted input word
	always_comb begin
		push = '0;
		if (accept) begin
			case (cmd_e)
				CMD_START: begin
					if (baud_select != SEL_AUTO) begin
						push.valid        = 1'b1;
						push.data.divisor = fixed_div;
					end
				end
				CMD_EDGE: begin
					if (measuring_q && try_done) begin
						push.valid = 1'b1;
						if (min_next != NO_INTERVAL) begin
							push.data.divisor = min_next[15:4];
						end else begin
							push.data.status = 1'b1;
						end
					end
				end
				default: push = '0;
			endcase
		end
	end

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q   <= NO_INTERVAL;
			last_edge_time_q <= '0;
			overflow_count_q <= OVF_SAT;
			edge_count_q     <= '0;
			measuring_q      <= 1'b0;
		end else if (accept) begin
			case (cmd_e)
				CMD_START: begin
					min_interval_q   <= NO_INTERVAL;
					overflow_count_q <= OVF_SAT;
					edge_count_q     <= '0;
					measuring_q      <= (baud_select == SEL_AUTO);
				end
				CMD_TICK: begin
					if (measuring_q && overflow_count_q != OVF_SAT) begin
						overflow_count_q <= overflow_count_q + 8'd1;
					end
				end
				CMD_EDGE: begin
					if (measuring_q) begin
						min_interval_q   <= min_next;
						last_edge_time_q <= edge_time;
						overflow_count_q <= '0;
						edge_count_q     <= try_done ? 4'd0 : edge_next;
						if (try_done && min_next != NO_INTERVAL) begin
							measuring_q <= 1'b0;
						end
					end
				end
				default: measuring_q <= measuring_q;
			endcase
		end
	end

endmodule

[src/abd_outq.sv]
// two-word output queue, lets a new word in while one waits
`timescale 1ns / 1ps

module abd_outq import abd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  result_push_t push,
	output logic         full,
	output logic         out_valid,
	input  logic         out_ready,
	output result_t      head
);

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && out_ready;
	assign head      = entry_q[rd_ptr_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/uart_autobaud_divisor_top.sv]
// top level of the uart autobaud divisor block
`timescale 1ns / 1ps

// Works out a UART divisor (clock over sixteen times baud, minus one). A start
// word with baud_select 0..6 answers a fixed divisor at once; with select 7 the
// block measures the shortest valid interval between edge words and, at the
// EDGES_PER_TRY-th edge word of a try, answers that interval >> 4, or status 1
// (too slow, retrying) when none was valid. Each input word is handled by the
// state update logic and its result lands in a two-word output queue, so one
// word is taken every cycle while the queue has room; a result appears on the
// output in the cycle after its input word is accepted when the queue is empty,
// and later when earlier results still wait there. The user must write the
// baud_select register through cfg_we / cfg_wdata while idle; not enforced.

module uart_autobaud_divisor_top import abd_pkg::*; #(
	parameter int unsigned CLOCK_HZ      = 16000000,
	parameter int unsigned EDGES_PER_TRY = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] edge_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] divisor,
	output logic        status
);

	logic         sel_auto;
	logic [2:0]   sel_q;
	logic         accept;
	logic         full;
	result_push_t push;
	result_t      head;

	assign sel_auto  = (sel_q == SEL_AUTO);
	assign in_ready  = !full;
	assign accept    = in_valid && in_ready;
	assign divisor   = head.divisor;
	assign status    = head.status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEL_AUTO;
		end else if (cfg_we) begin
			sel_q <= cfg_wdata;
		end
	end

	abd_core #(
		.CLOCK_HZ      (CLOCK_HZ),
		.EDGES_PER_TRY (EDGES_PER_TRY)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.edge_time   (edge_time),
		.baud_select (sel_q),
		.push        (push)
	);

	abd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// a full queue always has a word to offer
	a_full_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("queue full without an output word");

	// a start with a fixed select yields a word next cycle
	a_fixed_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_START && !sel_auto) |=> out_valid)
		else $error("fixed select start gave no word");

	// a start in autobaud mode never yields a word
	a_auto_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_START && sel_auto) |-> !push.valid)
		else $error("autobaud start gave a word");

	// results come only from accepted input words
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> accept)
		else $error("result word without accepted input");

endmodule
